[hw/rtl/mkdlp_pkg.sv]
// Package for the multi-key debouncer with long-press detection.
// Holds the key count, field widths, threshold reset value and the lane result type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mkdlp_pkg;

  localparam int NUM_KEYS    = 7;
  localparam int HISTORY_LEN = 3;
  localparam int FIELD_W     = 7;
  localparam int CNT_W       = 8;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(50);

  typedef struct packed {
    logic press_event;
    logic held;
    logic long_press;
  } lane_out_t;

endpackage

[hw/rtl/mkdlp_lane.sv]
// One key lane: sample history, pressed and long flags, and hold counter.
// Produces this scan's event and flags for its key.
// Depends on mkdlp_pkg.
`timescale 1ns / 1ps

module mkdlp_lane
  import mkdlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             level,
  input  logic [CNT_W-1:0] threshold,
  output lane_out_t        result
);

  logic [HISTORY_LEN-1:0] hist_r, hist_nxt;
  logic                   pressed_r, pressed_nxt;
  logic                   long_r, long_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   press_evt;

  always_comb begin
    hist_nxt    = {hist_r[HISTORY_LEN-2:0], level};
    pressed_nxt = pressed_r;
    long_nxt    = long_r;
    cnt_nxt     = cnt_r;
    press_evt   = 1'b0;
    if (hist_nxt == '0) begin
      if (!pressed_r) begin
        pressed_nxt = 1'b1;
        cnt_nxt     = '0;
        press_evt   = 1'b1;
      end else if (!long_r) begin
        if (cnt_r < threshold) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          long_nxt = 1'b1;
          cnt_nxt  = '0;
        end
      end
    end else begin
      pressed_nxt = 1'b0;
      long_nxt    = 1'b0;
      cnt_nxt     = '0;
    end
  end

  assign result.press_event = press_evt;
  assign result.held        = pressed_nxt;
  assign result.long_press  = long_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '0;
      pressed_r <= 1'b0;
      long_r    <= 1'b0;
      cnt_r     <= '0;
    end else if (advance) begin
      hist_r    <= hist_nxt;
      pressed_r <= pressed_nxt;
      long_r    <= long_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/mkdlp_merge.sv]
// Merge stage: gathers the lane results into the three output fields and
// holds them in the output register with the result handshake.
// Depends on mkdlp_pkg.
`timescale 1ns / 1ps

module mkdlp_merge
  import mkdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  lane_out_t          lanes [NUM_KEYS],
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_press_event,
  output logic [FIELD_W-1:0] out_key_held,
  output logic [FIELD_W-1:0] out_long_press
);

  logic                valid_r, valid_nxt;
  logic [FIELD_W-1:0]  ev_r, held_r, long_r;
  logic [NUM_KEYS-1:0] ev_v, held_v, long_v;

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      ev_v[i]   = lanes[i].press_event;
      held_v[i] = lanes[i].held;
      long_v[i] = lanes[i].long_press;
    end
  end

  assign in_stall  = valid_r && out_stall;
  assign valid_nxt = in_take || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_r   <= FIELD_W'(ev_v);
      held_r <= FIELD_W'(held_v);
      long_r <= FIELD_W'(long_v);
    end
  end

  assign out_valid       = valid_r;
  assign out_press_event = ev_r;
  assign out_key_held    = held_r;
  assign out_long_press  = long_r;

  a_event_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((ev_r & ~held_r) == '0))
    else $error("press event on a key that is not held");

  a_long_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((long_r & ~held_r) == '0))
    else $error("long press on a key that is not held");

  a_event_not_long: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((ev_r & long_r) == '0))
    else $error("press event and long press on the same scan");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> valid_r)
    else $error("accepted transaction did not reach the output register");

endmodule

[hw/rtl/multi_key_debounce_long_press.sv]
// Top level of the multi-key debouncer with long-press detection.
// Holds the threshold register, the key lanes and the merge stage.
// Depends on mkdlp_pkg, mkdlp_lane and mkdlp_merge.
//
// Each input transaction is one scan tick carrying the raw active-low key
// levels on in_key_levels. Every accepted scan yields exactly one result
// transaction: press_event, key_held and long_press for all keys.
// The result is loaded into the output register at the edge that accepts
// the scan. Throughput is one scan per cycle while in_stall is low; one lane
// per key updates its history, flags and counter in the accepting cycle.
// in_stall rises only while a result waits in the output register and the
// receiver holds out_stall; a result taken in the same cycle frees the
// register for the next scan. The user must write the threshold (cfg_wr_en,
// cfg_wr_data) only while the block is idle; the block does not enforce it.
// After reset the threshold is 50, all sample histories are zero and all
// flags and counters are clear, so a key already low on the first scan is
// reported pressed at once.
`timescale 1ns / 1ps

module multi_key_debounce_long_press
  import mkdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] in_key_levels,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_press_event,
  output logic [FIELD_W-1:0] out_key_held,
  output logic [FIELD_W-1:0] out_long_press,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data
);

  logic [CNT_W-1:0]    thr_r;
  logic                take;
  logic [NUM_KEYS-1:0] lvl_v;
  lane_out_t           lanes [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign take  = in_valid && !in_stall;
  assign lvl_v = NUM_KEYS'({{NUM_KEYS{1'b1}}, in_key_levels});

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    mkdlp_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (take),
      .level     (lvl_v[g]),
      .threshold (thr_r),
      .result    (lanes[g])
    );
  end

  mkdlp_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (take),
    .lanes           (lanes),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_press_event (out_press_event),
    .out_key_held    (out_key_held),
    .out_long_press  (out_long_press)
  );

endmodule
